@@ design/ppc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the polyphase preamble correlator.
// No dependencies; every other design file refers to it by scoped names.
package ppc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PATTERN_W  = 16;
  localparam int THRESH_W   = 39;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 39;
  localparam int GRP_TAPS   = 8;   // taps summed per first-level adder group

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 39'd10000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGN_PATTERN     = 2'd0,
    REG_DETECT_THRESHOLD = 2'd1
  } reg_idx_e;

endpackage

@@ design/ppc_in_if.sv @@
`timescale 1ns / 1ps
// Input stream channel: one I/Q sample plus end-of-packet marker.
// Depends on ppc_pkg for the sample type.
interface ppc_in_if;
  logic             valid;
  logic             ready;
  ppc_pkg::sample_t sample_i;
  ppc_pkg::sample_t sample_q;
  logic             in_last;

  modport source (output valid, output sample_i, output sample_q, output in_last,
                  input ready);
  modport sink   (input valid, input sample_i, input sample_q, input in_last,
                  output ready);
endinterface

@@ design/ppc_out_if.sv @@
`timescale 1ns / 1ps
// Output stream channel: gated I/Q sample plus end-of-packet marker.
// Depends on ppc_pkg for the sample type.
interface ppc_out_if;
  logic             valid;
  logic             ready;
  ppc_pkg::sample_t out_i;
  ppc_pkg::sample_t out_q;
  logic             out_last;

  modport source (output valid, output out_i, output out_q, output out_last,
                  input ready);
  modport sink   (input valid, input out_i, input out_q, input out_last,
                  output ready);
endinterface

@@ design/ppc_win_store.sv @@
`timescale 1ns / 1ps
// Per-phase tap window store: row memory, phase counter, row valid bits.
// Depends on ppc_pkg for the sample width.
module ppc_win_store #(
  parameter int TAPS   = 16,
  parameter int PHASES = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    push_i,  // item accepted this cycle
  input  logic [(TAPS-1)*ppc_pkg::SAMPLE_W-1:0]   row_i,   // updated row for current phase
  output logic [(TAPS-1)*ppc_pkg::SAMPLE_W-1:0]   row_o    // stored row for current phase
);

  localparam int ROW_W = (TAPS - 1) * ppc_pkg::SAMPLE_W;
  localparam int PH_W  = (PHASES > 1) ? $clog2(PHASES) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(PHASES - 1);

  logic [ROW_W-1:0]  mem [PHASES];
  logic [PH_W-1:0]   phase_q, phase_d;
  logic [PHASES-1:0] row_vld_q;
  logic [ROW_W-1:0]  row_q;
  logic [PH_W-1:0]   rd_addr;

  assign phase_d = (phase_q == PH_LAST) ? '0 : phase_q + PH_W'(1);
  assign rd_addr = push_i ? phase_d : phase_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[phase_q] <= row_i;
    end
  end

  // Registered read; a write to the row being fetched is forwarded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      row_vld_q <= '0;
      row_q     <= '0;
    end else begin
      if (push_i) begin
        phase_q            <= phase_d;
        row_vld_q[phase_q] <= 1'b1;
      end
      if (push_i && (rd_addr == phase_q)) begin
        row_q <= row_i;
      end else if (row_vld_q[rd_addr]) begin
        row_q <= mem[rd_addr];
      end else begin
        row_q <= '0;
      end
    end
  end

  assign row_o = row_q;

endmodule

@@ design/polyphase_preamble_correlator_top.sv @@
`timescale 1ns / 1ps
// Top level of the polyphase preamble sign correlator with frame gate.
// Depends on ppc_pkg, ppc_in_if, ppc_out_if and ppc_win_store.
//
// Usage:
//   in_i  : sink of I/Q samples (valid/ready); one transaction per sample.
//   out_o : source of gated samples; exactly one transaction per input.
//   cfg_* : register writes, index 0 = sign pattern, 1 = detect threshold;
//           other indexes are dropped. Write only while the block is idle.
// Each I sample is shifted into the tap window of its phase class (PHASES
// classes, TAPS taps each), the window is summed with per-tap signs, and the
// squared sum is compared against the threshold. Above it, the sample goes
// out unchanged; otherwise I and Q are zeroed. The last flag always passes.
// Path: a sample accepted on in_i passes the window, group sum, total, square
// and gate/output registers in that order before it shows on out_o.
// Throughput: one transaction per cycle unless out_o stalls; each pipeline stage
// holds one item, and the window store reads and writes one phase row per cycle.
// Stall: when out_o is not ready, bubbles in the pipe still fill, and in_i
// drops ready only once all five stages hold an item.
// Reset: phase counter zero, every window reads as zero (per-row valid bits,
// no clearing pass), pattern zero, threshold 10000, pipeline empty.
module polyphase_preamble_correlator_top #(
  parameter int TAPS   = 16,
  parameter int PHASES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ppc_in_if.sink                         in_i,
  ppc_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SW    = ppc_pkg::SAMPLE_W;
  localparam int PW    = ppc_pkg::PATTERN_W;
  localparam int TW    = ppc_pkg::THRESH_W;
  localparam int GT    = ppc_pkg::GRP_TAPS;
  localparam int ROW_W = (TAPS - 1) * SW;
  localparam int NGRP  = (TAPS + GT - 1) / GT;
  localparam int GRP_W = SW + 1 + $clog2(GT);
  localparam int SUM_W = SW + 1 + $clog2(TAPS);
  localparam int SQ_W  = 2 * SUM_W;
  localparam int CMP_W = (SQ_W > TW) ? SQ_W : TW;

  // ---------------- configuration registers ----------------
  logic [PW-1:0] sign_pattern_q;
  logic [TW-1:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_pattern_q <= '0;
      thresh_q       <= ppc_pkg::THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ppc_pkg::REG_SIGN_PATTERN) begin
        sign_pattern_q <= cfg_data_i[PW-1:0];
      end else if (cfg_idx_i == ppc_pkg::REG_DETECT_THRESHOLD) begin
        thresh_q <= cfg_data_i[TW-1:0];
      end
    end
  end

  // Taps past the pattern width have no bit and are subtracted.
  logic [TAPS-1:0] pat_ext;
  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      pat_ext[k] = (k < PW) ? sign_pattern_q[k % PW] : 1'b0;
    end
  end

  // ---------------- stage enables (bubble collapsing) ----------------
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic en1, en2, en3, en4, eno;
  logic in_fire;

  assign eno = !vo_q || out_o.ready;
  assign en4 = !v4_q || eno;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready = en1;
  assign in_fire    = in_i.valid && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (eno) vo_q <= v4_q;
    end
  end

  // ---------------- window update ----------------
  logic [ROW_W-1:0]  row_cur, row_new;
  ppc_pkg::sample_t  win_new [TAPS];

  ppc_win_store #(
    .TAPS   (TAPS),
    .PHASES (PHASES)
  ) u_win_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_fire),
    .row_i  (row_new),
    .row_o  (row_cur)
  );

  always_comb begin
    win_new[0] = in_i.sample_i;
    for (int k = 1; k < TAPS; k++) begin
      win_new[k] = row_cur[(k-1)*SW +: SW];
    end
    for (int j = 0; j < TAPS - 1; j++) begin
      row_new[j*SW +: SW] = win_new[j];
    end
  end

  // ---------------- stage 1: window ----------------
  ppc_pkg::sample_t win1_q [TAPS];
  ppc_pkg::sample_t si1_q, sq1_q;
  logic             last1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      win1_q  <= win_new;
      si1_q   <= in_i.sample_i;
      sq1_q   <= in_i.sample_q;
      last1_q <= in_i.in_last;
    end
  end

  // ---------------- stage 2: signed group sums ----------------
  logic signed [GRP_W-1:0] grp_d [NGRP];
  logic signed [GRP_W-1:0] grp2_q [NGRP];
  ppc_pkg::sample_t        si2_q, sq2_q;
  logic                    last2_q;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GT; j++) begin
        if (g * GT + j < TAPS) begin
          if (pat_ext[g*GT + j]) begin
            grp_d[g] = grp_d[g] + GRP_W'(win1_q[g*GT + j]);
          end else begin
            grp_d[g] = grp_d[g] - GRP_W'(win1_q[g*GT + j]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      grp2_q  <= grp_d;
      si2_q   <= si1_q;
      sq2_q   <= sq1_q;
      last2_q <= last1_q;
    end
  end

  // ---------------- stage 3: total ----------------
  logic signed [SUM_W-1:0] sum_d, sum3_q;
  ppc_pkg::sample_t        si3_q, sq3_q;
  logic                    last3_q;

  always_comb begin
    sum_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      sum_d = sum_d + SUM_W'(grp2_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sum3_q  <= sum_d;
      si3_q   <= si2_q;
      sq3_q   <= sq2_q;
      last3_q <= last2_q;
    end
  end

  // ---------------- stage 4: square ----------------
  logic signed [SQ_W-1:0] sq_d;
  logic [SQ_W-1:0]        sq4_q;
  ppc_pkg::sample_t       si4_q, sq4s_q;
  logic                   last4_q;

  assign sq_d = sum3_q * sum3_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      sq4_q   <= sq_d;
      si4_q   <= si3_q;
      sq4s_q  <= sq3_q;
      last4_q <= last3_q;
    end
  end

  // ---------------- output: threshold gate ----------------
  logic             hit;
  ppc_pkg::sample_t oi_q, oq_q;
  logic             olast_q;

  assign hit = CMP_W'(sq4_q) > CMP_W'(thresh_q);

  always_ff @(posedge clk_i) begin
    if (eno) begin
      oi_q    <= hit ? si4_q  : '0;
      oq_q    <= hit ? sq4s_q : '0;
      olast_q <= last4_q;
    end
  end

  assign out_o.valid    = vo_q;
  assign out_o.out_i    = oi_q;
  assign out_o.out_q    = oq_q;
  assign out_o.out_last = olast_q;

  // ---------------- assertions ----------------
  // Input backpressure only when every stage is occupied.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q && v4_q && vo_q))
    else $error("input stalled with a bubble in the pipeline");

  // An accepted sample always lands in stage 1.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted sample lost at stage 1");

  // A held output item must not be overwritten by the stage behind it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && !out_o.ready && v4_q) |=> (vo_q && v4_q))
    else $error("stage 4 item dropped during output stall");

endmodule

@@ test/tb_polyphase_preamble_correlator_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for polyphase_preamble_correlator_top: a scoreboard
// class predicts each gated sample, and plain tasks drive the input stream.
// Depends on ppc_pkg, ppc_in_if, ppc_out_if and the design top level.

class gate_scoreboard #(int TAPS = 16, int PHASES = 16);

  typedef struct packed {
    ppc_pkg::sample_t gi;
    ppc_pkg::sample_t gq;
    logic             last;
  } gated_t;

  ppc_pkg::sample_t                windows [PHASES][TAPS];
  int                              phase;
  logic [ppc_pkg::PATTERN_W-1:0]   pattern;
  logic [ppc_pkg::THRESH_W-1:0]    threshold;
  gated_t                          gated_q [$];
  int                              errors;

  function new();
    foreach (windows[p, k]) windows[p][k] = '0;
    phase     = 0;
    pattern   = '0;
    threshold = ppc_pkg::THRESHOLD_RESET;
    errors    = 0;
  endfunction

  function void write_reg(logic [ppc_pkg::CFG_IDX_W-1:0] idx,
                          logic [ppc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ppc_pkg::REG_SIGN_PATTERN:     pattern   = data[ppc_pkg::PATTERN_W-1:0];
      ppc_pkg::REG_DETECT_THRESHOLD: threshold = data[ppc_pkg::THRESH_W-1:0];
      default: ;
    endcase
  endfunction

  // Shift the I sample into its class window, correlate, square, gate.
  function void note_sample(ppc_pkg::sample_t si, ppc_pkg::sample_t sq, logic last);
    longint          acc;
    longint unsigned power;
    gated_t          exp_item;
    acc = 0;
    for (int k = TAPS - 1; k > 0; k--) windows[phase][k] = windows[phase][k-1];
    windows[phase][0] = si;
    for (int k = 0; k < TAPS; k++) begin
      if ((k < ppc_pkg::PATTERN_W) && pattern[k]) acc += windows[phase][k];
      else acc -= windows[phase][k];
    end
    power = longint'(acc * acc);
    exp_item.last = last;
    if (power > {25'd0, threshold}) begin
      exp_item.gi = si;
      exp_item.gq = sq;
    end else begin
      exp_item.gi = '0;
      exp_item.gq = '0;
    end
    gated_q.push_back(exp_item);
    phase = (phase >= PHASES - 1) ? 0 : phase + 1;
  endfunction

  function void check_gated(ppc_pkg::sample_t oi, ppc_pkg::sample_t oq, logic last);
    gated_t exp_item;
    if (gated_q.size() == 0) begin
      $display("%0t: unexpected result i=%0d q=%0d last=%0b", $time, oi, oq, last);
      errors++;
      return;
    end
    exp_item = gated_q.pop_front();
    if (oi !== exp_item.gi) begin
      $display("%0t: out_i expected %0d actual %0d", $time, exp_item.gi, oi);
      errors++;
    end
    if (oq !== exp_item.gq) begin
      $display("%0t: out_q expected %0d actual %0d", $time, exp_item.gq, oq);
      errors++;
    end
    if (last !== exp_item.last) begin
      $display("%0t: out_last expected %0b actual %0b", $time, exp_item.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return gated_q.size();
  endfunction

endclass

module tb_polyphase_preamble_correlator_top;

  localparam int TAPS       = 16;
  localparam int PHASES     = 16;
  localparam int RAND_ITEMS = 750;
  localparam int ITEM_TOTAL = 24 + RAND_ITEMS;  // directed plus random items
  localparam int IDLE_LIMIT = 1000;   // cycles without any transaction or register write
  localparam int DRAIN_WAIT = 6;      // pipeline depth plus margin

  // Register indexes the block has no register for; writes must be dropped.
  localparam logic [ppc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [ppc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam logic [ppc_pkg::THRESH_W-1:0] THR_FULL_SCALE = 39'h40_0000_0000;  // 2^38
  localparam logic [ppc_pkg::THRESH_W-1:0] THR_BELOW_FULL = 39'h3F_FFFF_FFFF;

  // Receiver ready patterns.
  typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_e;

  logic                           clk_i;
  logic                           rst_n;
  logic                           cfg_we;
  logic [ppc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data;

  ppc_in_if  in_if ();
  ppc_out_if out_if ();

  gate_scoreboard #(TAPS, PHASES) sb;

  rx_mode_e  rx_mode;
  int        rx_hold;
  int        rx_tick;
  int        idle_cycles;
  int        burst_left;
  bit        steady_send;
  int        items_sent;

  polyphase_preamble_correlator_top #(
    .TAPS   (TAPS),
    .PHASES (PHASES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Transaction monitor: values are sampled at the edge, before the
  // nonblocking updates of that edge land.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_gated(out_if.out_i, out_if.out_q, out_if.out_last);
      if (in_if.valid && in_if.ready)
        sb.note_sample(in_if.sample_i, in_if.sample_q, in_if.in_last);
    end
  end

  // Watchdog: any transaction or register write counts as progress.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL polyphase_preamble_correlator_top");
        $finish;
      end
    end
  end

  // Output backpressure, one pattern per test phase.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      rx_tick      <= 0;
      rx_hold      <= 0;
      out_if.ready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1;
      case (rx_mode)
        RX_STEADY: out_if.ready <= 1'b1;
        RX_RANDOM: out_if.ready <= ($urandom_range(0, 9) < 7);
        // periodic stall pattern driven by the tick counter
        RX_PERIODIC: out_if.ready <= ((rx_tick % 7) < 5);
        RX_LONG: begin
          if (rx_hold == 0) begin
            out_if.ready <= ~out_if.ready;
            rx_hold <= out_if.ready ? $urandom_range(5, 40) : $urandom_range(1, 20);
          end else begin
            rx_hold <= rx_hold - 1;
          end
        end
        default: out_if.ready <= 1'b1;
      endcase
    end
  end

  // One register write; the strobe drops on the following edge.
  task automatic write_reg(input logic [ppc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ppc_pkg::CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one sample and wait for its transaction. Bursts of random length
  // are separated by random gaps unless the phase asks for steady sending.
  task automatic push_sample(input ppc_pkg::sample_t si, input ppc_pkg::sample_t sq,
                             input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = steady_send ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid    <= 1'b1;
    in_if.sample_i <= si;
    in_if.sample_q <= sq;
    in_if.in_last  <= last;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  // Drain: stop sending, let the monitor log the last accepted sample, wait
  // out every outstanding result, then let the pipe go quiet before the
  // next register write.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  initial begin
    ppc_pkg::sample_t              corner_i [20];
    logic [ppc_pkg::PATTERN_W-1:0] cur_pattern;
    logic [ppc_pkg::THRESH_W-1:0]  cur_thr;
    logic [63:0]                   wide;
    int                            amp;
    int                            noise;
    int                            kind;
    int                            start;
    int                            len;
    int                            v;
    int                            phase_no;
    bit                            extreme;

    corner_i = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
                 16'sh5555, 16'shAAAA, 16'sh0100, 16'shFF00, 16'sh7FFF,
                 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0064, 16'shFF9C,
                 16'sh0000, 16'sh1000, 16'shF000, 16'sh7FFF, 16'sh8000};

    sb = new();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.sample_i = '0;
    in_if.sample_q = '0;
    in_if.in_last  = 1'b0;
    rx_mode        = RX_STEADY;
    burst_left     = 0;
    steady_send    = 1'b1;
    items_sent     = 0;

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings (all taps subtracted, threshold 10000), field
    // extremes on I and Q, last toggling, and more than one pass of the
    // phase counter so it wraps.
    for (int n = 0; n < 20; n++)
      push_sample(corner_i[n], ~corner_i[n], n[0]);
    settle();

    // Writes to indexes without a register must leave the settings alone.
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 39'd0);
    rx_mode = RX_RANDOM;
    steady_send = 1'b0;
    for (int n = 0; n < 4; n++)
      push_sample(ppc_pkg::sample_t'($urandom()), ppc_pkg::sample_t'($urandom()),
                  1'($urandom()));
    settle();

    // Random phases: each picks settings, a ready pattern and a kind of
    // traffic. Frames are a sign-coded preamble followed by payload; the
    // rest is plain noise or a stream of extreme values.
    phase_no = 0;
    while (items_sent < ITEM_TOTAL) begin
      extreme = 1'b0;
      amp = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300)
                                        : $urandom_range(1000, 32767);
      kind = $urandom_range(0, 5);
      cur_pattern = 16'($urandom());
      wide = {$urandom(), $urandom()};
      cur_thr = ppc_pkg::THRESH_W'(longint'(amp) * amp * $urandom_range(1, 300));
      case ($urandom_range(0, 7))
        0: cur_thr = '0;
        1: cur_thr = THR_FULL_SCALE;
        2: cur_thr = THR_BELOW_FULL;
        3: cur_thr = '1;
        4: cur_thr = wide[ppc_pkg::THRESH_W-1:0];
        default: ;
      endcase
      // Fixed openers: a full-scale preamble against both sides of the
      // largest possible square, then zero and maximum thresholds.
      case (phase_no)
        0: begin
          cur_pattern = '0; cur_thr = THR_BELOW_FULL; kind = 0; extreme = 1'b1;
        end
        1: begin
          cur_pattern = '0; cur_thr = THR_FULL_SCALE; kind = 0; extreme = 1'b1;
        end
        2: begin cur_pattern = '1; cur_thr = '0; kind = 3; end
        3: begin cur_pattern = '1; cur_thr = '1; kind = 5; end
        default: ;
      endcase

      // upper data bits are junk the pattern register must drop
      write_reg(ppc_pkg::REG_SIGN_PATTERN, {23'($urandom_range(0, 8388607)), cur_pattern});
      write_reg(ppc_pkg::REG_DETECT_THRESHOLD, cur_thr);
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      steady_send = ($urandom_range(0, 3) == 0);

      if (kind <= 2) begin
        // Preamble: sample n lands at tap 15 - n/16 of its class when the
        // last 16 arrive, so its sign follows that pattern bit. Some frames
        // start late to model a broken preamble.
        noise = extreme ? 0 : $urandom_range(0, amp / 4);
        start = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0;
        for (int n = start; n < 256 && items_sent < ITEM_TOTAL; n++) begin
          if (extreme)
            v = cur_pattern[15 - n / 16] ? 32767 : -32768;
          else
            v = (cur_pattern[15 - n / 16] ? amp : -amp)
                + int'($urandom_range(0, 2 * noise)) - noise;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          push_sample(ppc_pkg::sample_t'(v), ppc_pkg::sample_t'($urandom()), 1'b0);
        end
        len = $urandom_range(16, 48);
        for (int n = 0; n < len && items_sent < ITEM_TOTAL; n++)
          push_sample(ppc_pkg::sample_t'($urandom()), ppc_pkg::sample_t'($urandom()),
                      n == len - 1);
      end else if (kind <= 4) begin
        len = $urandom_range(24, 96);
        for (int n = 0; n < len && items_sent < ITEM_TOTAL; n++)
          push_sample(ppc_pkg::sample_t'($urandom()), ppc_pkg::sample_t'($urandom()),
                      ($urandom_range(0, 7) == 0));
      end else begin
        len = $urandom_range(24, 64);
        for (int n = 0; n < len && items_sent < ITEM_TOTAL; n++)
          push_sample(corner_i[$urandom_range(0, 19)], corner_i[$urandom_range(0, 19)],
                      1'($urandom()));
      end
      settle();
      phase_no++;
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS polyphase_preamble_correlator_top");
    end else begin
      $display("FAIL polyphase_preamble_correlator_top");
    end
    $finish;
  end

endmodule
